// ===== hdl/srq_pkg.sv =====
// srq_pkg: shared types and constants for the sequenced ring queue
// no dependencies; imported by sequenced_ring_queue and sequenced_ring_queue_tb
`timescale 1ns / 1ps

package srq_pkg;

  localparam int unsigned CMD_W          = 3;
  localparam int unsigned TICKET_W       = 6;
  localparam int unsigned DEF_CAPACITY   = 16;
  localparam int unsigned DEF_DATA_WIDTH = 32;

  typedef enum logic [CMD_W-1:0] {
    CMD_ENQ        = 3'd0,
    CMD_DEQ        = 3'd1,
    CMD_RES_ENQ    = 3'd2,
    CMD_RES_DEQ    = 3'd3,
    CMD_COMMIT_ENQ = 3'd4,
    CMD_COMMIT_DEQ = 3'd5
  } cmd_e;

endpackage

// ===== hdl/sequenced_ring_queue.sv =====
// sequenced_ring_queue: bounded queue with per-slot sequence tags, ticketed reserve/commit
// depends on srq_pkg (command codes, field widths, default parameters)
//
//   channel   | direction | handshake           | payload
//   ----------+-----------+---------------------+------------------------------------
//   request   | in        | start_i / busy_o    | command_i, data_in_i, ticket_i
//   response  | out       | done_o (one cycle)  | ok_o, data_out_o, ticket_out_o
//
// one transaction per cycle; busy_o stays low, so a request is taken on every edge
// with start_i high. done_o follows acceptance through the request register, then the
// slot tag read/compare lands in the result register, which drives done_o and the payload.
// reset (rst_ni low) sets every slot tag to its own index and both positions to zero;
// slot data is not cleared. the receiver cannot stall: done_o is a one-cycle strobe.
`timescale 1ns / 1ps

module sequenced_ring_queue #(
  parameter int unsigned CAPACITY   = srq_pkg::DEF_CAPACITY,
  parameter int unsigned DATA_WIDTH = srq_pkg::DEF_DATA_WIDTH
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic [srq_pkg::CMD_W-1:0]     command_i,
  input  logic [DATA_WIDTH-1:0]         data_in_i,
  input  logic [srq_pkg::TICKET_W-1:0]  ticket_i,
  output logic                          done_o,
  output logic                          ok_o,
  output logic [DATA_WIDTH-1:0]         data_out_o,
  output logic [srq_pkg::TICKET_W-1:0]  ticket_out_o
);

  import srq_pkg::*;

  localparam int unsigned POS_MOD = 4 * CAPACITY;
  localparam int unsigned POS_W   = $clog2(POS_MOD);
  localparam int unsigned IDX_W   = $clog2(CAPACITY);
  localparam int unsigned TK_W    = ((POS_W > TICKET_W) ? POS_W : TICKET_W) + 1;

  // ---------------------------------------------------------------- helpers
  function automatic logic [POS_W-1:0] pos_inc(input logic [POS_W-1:0] p);
    logic [POS_W-1:0] r;
    if (p == POS_W'(POS_MOD - 1)) r = '0;
    else r = p + POS_W'(1);
    return r;
  endfunction

  // pos is below 4*CAPACITY, so three subtractions reach the slot index
  function automatic logic [IDX_W-1:0] slot_of(input logic [POS_W-1:0] p);
    logic [POS_W-1:0] v;
    v = p;
    for (int i = 0; i < 3; i++) begin
      if (v >= POS_W'(CAPACITY)) v = v - POS_W'(CAPACITY);
    end
    return v[IDX_W-1:0];
  endfunction

  // ticket is at most 63 and the ring modulus at least 8: seven steps suffice
  function automatic logic [POS_W-1:0] ticket_wrap(input logic [TICKET_W-1:0] t);
    logic [TK_W-1:0] v;
    v = TK_W'(t);
    for (int i = 0; i < 8; i++) begin
      if (v >= TK_W'(POS_MOD)) v = v - TK_W'(POS_MOD);
    end
    return v[POS_W-1:0];
  endfunction

  function automatic logic [POS_W-1:0] pos_add_cap(input logic [POS_W-1:0] p);
    logic [POS_W:0] s;
    s = {1'b0, p} + (POS_W+1)'(CAPACITY);
    if (s >= (POS_W+1)'(POS_MOD)) s = s - (POS_W+1)'(POS_MOD);
    return s[POS_W-1:0];
  endfunction

  function automatic logic [TICKET_W-1:0] pos_to_ticket(input logic [POS_W-1:0] p);
    logic [TK_W-1:0] e;
    e = TK_W'(p);
    return e[TICKET_W-1:0];
  endfunction

  // ---------------------------------------------------------------- request register
  logic                  req_valid_q;
  logic [CMD_W-1:0]      req_cmd_q;
  logic [DATA_WIDTH-1:0] req_data_q;
  logic [TICKET_W-1:0]   req_ticket_q;

  assign busy_o = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid_q <= 1'b0;
    end else begin
      req_valid_q <= start_i && !busy_o;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i && !busy_o) begin
      req_cmd_q    <= command_i;
      req_data_q   <= data_in_i;
      req_ticket_q <= ticket_i;
    end
  end

  // ---------------------------------------------------------------- state
  logic [POS_W-1:0]      tag_q [CAPACITY];
  logic [DATA_WIDTH-1:0] slot_data [CAPACITY];
  logic [POS_W-1:0]      enq_pos_q, enq_pos_d;
  logic [POS_W-1:0]      deq_pos_q, deq_pos_d;

  // ---------------------------------------------------------------- execute
  cmd_e                  cmd;
  logic                  enq_kind;
  logic [IDX_W-1:0]      pos_slot;
  logic [POS_W-1:0]      expected_tag;
  logic                  tag_hit;
  logic [POS_W-1:0]      tk_pos;
  logic [IDX_W-1:0]      tk_slot;

  logic                  tag_we;
  logic [IDX_W-1:0]      tag_wa;
  logic [POS_W-1:0]      tag_wd;
  logic                  data_we;
  logic [IDX_W-1:0]      data_wa;
  logic                  rd_en;
  logic                  ok_d;
  logic [TICKET_W-1:0]   ticket_out_d;

  assign cmd      = cmd_e'(req_cmd_q);
  assign enq_kind = (req_cmd_q == CMD_ENQ) || (req_cmd_q == CMD_RES_ENQ);

  // one tag read: the enqueue side or the dequeue side, by command
  assign pos_slot     = enq_kind ? slot_of(enq_pos_q) : slot_of(deq_pos_q);
  assign expected_tag = enq_kind ? enq_pos_q : pos_inc(deq_pos_q);
  assign tag_hit      = (tag_q[pos_slot] == expected_tag);

  assign tk_pos  = ticket_wrap(req_ticket_q);
  assign tk_slot = slot_of(tk_pos);

  always_comb begin
    enq_pos_d    = enq_pos_q;
    deq_pos_d    = deq_pos_q;
    tag_we       = 1'b0;
    tag_wa       = pos_slot;
    tag_wd       = '0;
    data_we      = 1'b0;
    data_wa      = pos_slot;
    rd_en        = 1'b0;
    ok_d         = 1'b0;
    ticket_out_d = '0;
    case (cmd)
      CMD_ENQ: begin
        if (tag_hit) begin
          enq_pos_d = pos_inc(enq_pos_q);
          tag_we    = 1'b1;
          tag_wd    = pos_inc(enq_pos_q);
          data_we   = 1'b1;
          ok_d      = 1'b1;
        end
      end
      CMD_DEQ: begin
        if (tag_hit) begin
          deq_pos_d = pos_inc(deq_pos_q);
          tag_we    = 1'b1;
          tag_wd    = pos_add_cap(deq_pos_q);
          rd_en     = 1'b1;
          ok_d      = 1'b1;
        end
      end
      CMD_RES_ENQ: begin
        if (tag_hit) begin
          enq_pos_d    = pos_inc(enq_pos_q);
          ok_d         = 1'b1;
          ticket_out_d = pos_to_ticket(enq_pos_q);
        end
      end
      CMD_RES_DEQ: begin
        if (tag_hit) begin
          deq_pos_d    = pos_inc(deq_pos_q);
          rd_en        = 1'b1;
          ok_d         = 1'b1;
          ticket_out_d = pos_to_ticket(deq_pos_q);
        end
      end
      CMD_COMMIT_ENQ: begin
        tag_we  = 1'b1;
        tag_wa  = tk_slot;
        tag_wd  = pos_inc(tk_pos);
        data_we = 1'b1;
        data_wa = tk_slot;
        ok_d    = 1'b1;
      end
      CMD_COMMIT_DEQ: begin
        tag_we = 1'b1;
        tag_wa = tk_slot;
        tag_wd = pos_add_cap(tk_pos);
        ok_d   = 1'b1;
      end
      default: begin
        ok_d = 1'b0;
      end
    endcase
  end

  // ---------------------------------------------------------------- registers
  logic                  done_q;
  logic                  ok_q;
  logic [TICKET_W-1:0]   ticket_out_q;
  logic [DATA_WIDTH-1:0] data_out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CAPACITY; i++) begin
        tag_q[i] <= POS_W'(i);
      end
      enq_pos_q <= '0;
      deq_pos_q <= '0;
      done_q    <= 1'b0;
    end else begin
      done_q <= req_valid_q;
      if (req_valid_q) begin
        enq_pos_q <= enq_pos_d;
        deq_pos_q <= deq_pos_d;
        if (tag_we) begin
          tag_q[tag_wa] <= tag_wd;
        end
      end
    end
  end

  // slot data store and result payload
  always_ff @(posedge clk_i) begin
    if (req_valid_q) begin
      ok_q         <= ok_d;
      ticket_out_q <= ticket_out_d;
      data_out_q   <= rd_en ? slot_data[pos_slot] : '0;
      if (data_we) begin
        slot_data[data_wa] <= req_data_q;
      end
    end
  end

  assign done_o       = done_q;
  assign ok_o         = ok_q;
  assign data_out_o   = data_out_q;
  assign ticket_out_o = ticket_out_q;

  // ---------------------------------------------------------------- assertions
  a_enq_pos_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (enq_pos_q != $past(enq_pos_q)) |-> (enq_pos_q == pos_inc($past(enq_pos_q))))
    else $error("enqueue position moved by other than one step");

  a_deq_pos_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (deq_pos_q != $past(deq_pos_q)) |-> (deq_pos_q == pos_inc($past(deq_pos_q))))
    else $error("dequeue position moved by other than one step");

  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (enq_pos_q < POS_W'(POS_MOD - 1)) || (enq_pos_q == POS_W'(POS_MOD - 1)))
    else $error("enqueue position outside the ring");

  a_fail_payload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !ok_o) |-> ((data_out_o == '0) && (ticket_out_o == '0)))
    else $error("failed transaction carries payload");

endmodule

// ===== tb/sequenced_ring_queue_tb.sv =====
// sequenced_ring_queue_tb: self-checking testbench for the sequenced ring queue
// depends on srq_pkg (command codes, widths) and sequenced_ring_queue; the scoreboard
// class tracks slot tags and positions to predict every response
`timescale 1ns / 1ps

module sequenced_ring_queue_tb;
  import srq_pkg::*;

  localparam int unsigned CAP     = DEF_CAPACITY;
  localparam int unsigned DW      = DEF_DATA_WIDTH;
  localparam int unsigned N_ITEMS = 1350;

  // command codes the block must refuse
  localparam logic [CMD_W-1:0] CMD_RSVD_6 = 3'd6;
  localparam logic [CMD_W-1:0] CMD_RSVD_7 = 3'd7;

  typedef logic [TICKET_W-1:0] pos_t;

  typedef struct packed {
    logic          ok;
    logic [DW-1:0] data;
    pos_t          ticket;
  } reply_t;

  class ring_queue_scoreboard;
    pos_t          slot_tag [CAP];
    logic [DW-1:0] slot_word [CAP];
    pos_t          enq_pos;
    pos_t          deq_pos;
    reply_t        awaiting [$];
    int unsigned   n_checked;
    int unsigned   n_errors;
    int unsigned   n_refused;
    int unsigned   n_commits;
    int unsigned   n_invalid;

    function new();
      for (int i = 0; i < CAP; i++) begin
        slot_tag[i]  = pos_t'(i);
        slot_word[i] = '0;
      end
      enq_pos   = '0;
      deq_pos   = '0;
      n_checked = 0;
      n_errors  = 0;
      n_refused = 0;
      n_commits = 0;
      n_invalid = 0;
    endfunction

    function int unsigned slot_of(pos_t p);
      return p % CAP;
    endfunction

    function void fill_slot(pos_t p, logic [DW-1:0] word);
      slot_word[slot_of(p)] = word;
      slot_tag[slot_of(p)]  = pos_t'(p + 1'b1);
    endfunction

    function void free_slot(pos_t p);
      slot_tag[slot_of(p)] = pos_t'(p + pos_t'(CAP));
    endfunction

    // work out the response to an accepted request and queue it
    function reply_t note_request(logic [CMD_W-1:0] cmd, logic [DW-1:0] din, pos_t tk);
      reply_t r;
      pos_t   p;
      r = '0;
      case (cmd)
        CMD_ENQ, CMD_RES_ENQ: begin
          p = enq_pos;
          if (slot_tag[slot_of(p)] == p) begin
            enq_pos = pos_t'(p + 1'b1);
            r.ok    = 1'b1;
            if (cmd == CMD_ENQ) fill_slot(p, din);
            else r.ticket = p;
          end else begin
            n_refused++;
          end
        end
        CMD_DEQ, CMD_RES_DEQ: begin
          p = deq_pos;
          if (slot_tag[slot_of(p)] == pos_t'(p + 1'b1)) begin
            deq_pos = pos_t'(p + 1'b1);
            r.ok    = 1'b1;
            r.data  = slot_word[slot_of(p)];
            if (cmd == CMD_DEQ) free_slot(p);
            else r.ticket = p;
          end else begin
            n_refused++;
          end
        end
        CMD_COMMIT_ENQ: begin
          fill_slot(tk, din);
          r.ok = 1'b1;
          n_commits++;
        end
        CMD_COMMIT_DEQ: begin
          free_slot(tk);
          r.ok = 1'b1;
          n_commits++;
        end
        default: n_invalid++;
      endcase
      awaiting.push_back(r);
      return r;
    endfunction

    function void check_response(logic ok, logic [DW-1:0] data, pos_t ticket);
      reply_t e;
      if (awaiting.size() == 0) begin
        $error("response with nothing expected: ok=%0b data_out=%h ticket_out=%0d",
               ok, data, ticket);
        n_errors++;
        return;
      end
      e = awaiting.pop_front();
      n_checked++;
      if (ok !== e.ok) begin
        $error("ok: expected %0b, got %0b", e.ok, ok);
        n_errors++;
      end
      if (data !== e.data) begin
        $error("data_out: expected %h, got %h", e.data, data);
        n_errors++;
      end
      if (ticket !== e.ticket) begin
        $error("ticket_out: expected %0d, got %0d", e.ticket, ticket);
        n_errors++;
      end
    endfunction

    function int unsigned outstanding();
      return awaiting.size();
    endfunction
  endclass

  logic             clk_i     = 1'b0;
  logic             rst_ni    = 1'b0;
  logic             start_i   = 1'b0;
  logic [CMD_W-1:0] command_i = '0;
  logic [DW-1:0]    data_in_i = '0;
  pos_t             ticket_i  = '0;
  logic             busy_o;
  logic             done_o;
  logic             ok_o;
  logic [DW-1:0]    data_out_o;
  pos_t             ticket_out_o;

  ring_queue_scoreboard sb;
  bit                   idle_allowed;
  pos_t                 held_enq [$];  // enqueue tickets reserved, not yet committed
  pos_t                 held_deq [$];
  int unsigned          n_sent;
  int unsigned          n_drains;
  int unsigned          n_repairs;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  sequenced_ring_queue uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .busy_o       (busy_o),
    .command_i    (command_i),
    .data_in_i    (data_in_i),
    .ticket_i     (ticket_i),
    .done_o       (done_o),
    .ok_o         (ok_o),
    .data_out_o   (data_out_o),
    .ticket_out_o (ticket_out_o)
  );

  always @(posedge clk_i) begin
    if (rst_ni && done_o === 1'b1) sb.check_response(ok_o, data_out_o, ticket_out_o);
  end

  task automatic issue(input logic [CMD_W-1:0] cmd, input logic [DW-1:0] din,
                       input pos_t tk, output reply_t exp);
    int unsigned gap;
    if (idle_allowed && $urandom_range(0, 99) < 12) begin
      gap = $urandom_range(1, 19);
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start_i   <= 1'b1;
    command_i <= cmd;
    data_in_i <= din;
    ticket_i  <= tk;
    do @(posedge clk_i); while (busy_o !== 1'b0);
    exp = sb.note_request(cmd, din, tk);
    n_sent++;
  endtask

  // hold the request side until every response is back
  task automatic drain();
    start_i <= 1'b0;
    do @(posedge clk_i); while (sb.outstanding() != 0);
    n_drains++;
  endtask

  initial begin
    reply_t        r;
    int unsigned   k;
    int unsigned   pick;
    int unsigned   idx;
    int unsigned   mode_left;
    int unsigned   fail_run;
    bit            fill_mode;
    logic [DW-1:0] din;
    pos_t          tk;

    sb           = new();
    idle_allowed = 1'b0;
    n_sent       = 0;
    n_drains     = 0;
    n_repairs    = 0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty queue, refused commands, data extremes, out-of-order commits
    issue(CMD_DEQ,        32'h1234_5678, 6'h3F, r);
    issue(CMD_RES_DEQ,    32'hFFFF_FFFF, 6'h00, r);
    issue(CMD_RSVD_6,     32'hFFFF_FFFF, 6'h3F, r);
    issue(CMD_RSVD_7,     32'h0000_0000, 6'h2A, r);
    issue(CMD_ENQ,        32'h0000_0000, 6'h15, r);
    issue(CMD_ENQ,        32'hFFFF_FFFF, 6'h3F, r);
    issue(CMD_RES_ENQ,    32'h5555_5555, 6'h00, r);
    tk = r.ticket;
    issue(CMD_RES_DEQ,    32'h0000_0000, 6'h3F, r);
    issue(CMD_RES_DEQ,    32'h0000_0000, 6'h00, r);
    // slot reserved for enqueue but not committed reads as empty
    issue(CMD_RES_DEQ,    32'h0000_0000, 6'h00, r);
    issue(CMD_COMMIT_ENQ, 32'hA5A5_5A5A, tk, r);
    issue(CMD_COMMIT_DEQ, 32'hFFFF_FFFF, 6'd1, r);
    issue(CMD_COMMIT_DEQ, 32'h0000_0000, 6'd0, r);
    issue(CMD_DEQ,        32'h0000_0000, 6'h3F, r);
    issue(CMD_DEQ,        32'hFFFF_FFFF, 6'h00, r);
    drain();

    fill_mode = 1'b1;
    mode_left = 60;
    fail_run  = 0;
    for (k = 0; k < N_ITEMS; k++) begin
      if (mode_left == 0) begin
        fill_mode = 1'($urandom_range(0, 1));
        mode_left = $urandom_range(20, 80);
      end
      mode_left--;
      if (k % 50 == 0) idle_allowed = (k + 200 < N_ITEMS) && ($urandom_range(0, 3) != 0);
      if (k % 400 == 399) drain();

      if ($urandom_range(0, 15) == 0) din = $urandom_range(0, 1) ? {DW{1'b1}} : {DW{1'b0}};
      else din = DW'($urandom);
      tk = pos_t'($urandom);

      // stray commits can wedge the ring; put the head slots back in play
      if (fail_run >= 24 && held_enq.size() == 0 && held_deq.size() == 0) begin
        issue(CMD_COMMIT_DEQ, din, pos_t'(sb.enq_pos - pos_t'(CAP)), r);
        issue(CMD_COMMIT_ENQ, din, sb.deq_pos, r);
        fail_run = 0;
        n_repairs++;
      end

      pick = $urandom_range(0, 99);
      if (pick < 2) begin
        issue($urandom_range(0, 1) ? CMD_RSVD_6 : CMD_RSVD_7, din, tk, r);
      end else if (pick < 4) begin
        issue($urandom_range(0, 1) ? CMD_COMMIT_ENQ : CMD_COMMIT_DEQ, din, tk, r);
      end else if (pick < 30 && (held_enq.size() + held_deq.size()) != 0) begin
        if (held_enq.size() != 0 && (held_deq.size() == 0 || $urandom_range(0, 1))) begin
          idx = $urandom_range(0, held_enq.size() - 1);
          tk  = held_enq[idx];
          held_enq.delete(idx);
          issue(CMD_COMMIT_ENQ, din, tk, r);
        end else begin
          idx = $urandom_range(0, held_deq.size() - 1);
          tk  = held_deq[idx];
          held_deq.delete(idx);
          issue(CMD_COMMIT_DEQ, din, tk, r);
        end
      end else if (($urandom_range(0, 9) < 7) == fill_mode) begin
        if ($urandom_range(0, 2) == 0 && held_enq.size() < 4) begin
          issue(CMD_RES_ENQ, din, tk, r);
          if (r.ok) held_enq.push_back(r.ticket);
        end else begin
          issue(CMD_ENQ, din, tk, r);
        end
        fail_run = r.ok ? 0 : fail_run + 1;
      end else begin
        if ($urandom_range(0, 2) == 0 && held_deq.size() < 4) begin
          issue(CMD_RES_DEQ, din, tk, r);
          if (r.ok) held_deq.push_back(r.ticket);
        end else begin
          issue(CMD_DEQ, din, tk, r);
        end
        fail_run = r.ok ? 0 : fail_run + 1;
      end
    end

    // hand back every reservation still held
    while (held_enq.size() != 0) issue(CMD_COMMIT_ENQ, DW'($urandom), held_enq.pop_front(), r);
    while (held_deq.size() != 0) issue(CMD_COMMIT_DEQ, DW'($urandom), held_deq.pop_front(), r);

    start_i <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    $display("%0d transactions sent, %0d responses checked", n_sent, sb.n_checked);
    $display("%0d full/empty refusals, %0d commits, %0d invalid commands",
             sb.n_refused, sb.n_commits, sb.n_invalid);
    $display("request side held for a full drain %0d times, ring head repaired %0d times",
             n_drains, n_repairs);
    if (sb.n_errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("timeout: %0d responses still outstanding", sb.outstanding());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
